@@ hdl/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
// Used by rau_ctrl, rau_dpath and rational_arith_unit_top; no dependencies.
`default_nettype none

package rau_pkg;

    // Operation codes on the input word
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_CMP = 3'd4;
    localparam logic [2:0] CMD_NEG = 3'd5;

    // Compare outcome codes
    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_whole;
        logic [1:0]         order;
        logic [1:0]         status;
    } t_out_word;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL0,
        DP_MUL1,
        DP_MUL2,
        DP_PREP,
        DP_GCD,
        DP_DIVN_INIT,
        DP_DIVD_INIT,
        DP_DIV_STEP,
        DP_OUT
    } t_dp_op;

    // Datapath status returned to the controller
    typedef struct packed {
        logic skip;       // result known right after load
        logic early_done; // result known after product preparation
        logic gcd_done;
        logic div_last;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/rau_dpath.sv @@
// Datapath: shared multiplier, binary gcd, shift-subtract divider, result register.
// Depends on rau_pkg.
`default_nettype none

module rau_dpath
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire t_dp_op    i_op,
    input  wire t_in_word  i_in_word,
    output t_dp_stat       o_stat,
    output t_out_word      o_out_word
);

    localparam logic [63:0] LIM_POS = (64'd1 << (WORD_BITS - 1)) - 64'd1;
    localparam logic [63:0] LIM_NEG = 64'd1 << (WORD_BITS - 1);

    t_in_word           r_in;
    logic [30:0]        r_ad, r_bd;
    logic signed [63:0] r_p1, r_p2, r_den;
    logic [63:0]        r_n, r_d;
    logic               r_neg;
    logic [63:0]        r_gx, r_gy, r_g;
    logic [5:0]         r_k;
    logic [63:0]        r_q, r_rem;
    logic [5:0]         r_cnt;
    t_out_word          r_res;

    logic signed [32:0] n_ma, n_mb;
    logic signed [65:0] n_prod;
    logic signed [63:0] n_num;
    logic [64:0]        n_rem_sh;
    logic               n_ge;
    t_out_word          n_res;

    // Select multiplier operands per step and operation
    always_comb begin
        n_ma = {r_in.a_num[31], r_in.a_num};
        n_mb = {2'b00, r_bd};
        unique case (i_op)
            DP_MUL0: begin
                n_ma = {r_in.a_num[31], r_in.a_num};
                if (r_in.cmd == CMD_MUL) begin
                    n_mb = {r_in.b_num[31], r_in.b_num};
                end else if (r_in.cmd == CMD_NEG) begin
                    n_mb = -33'sd1;
                end else begin
                    n_mb = {2'b00, r_bd};
                end
            end
            DP_MUL1: begin
                n_ma = {r_in.b_num[31], r_in.b_num};
                n_mb = {2'b00, r_ad};
            end
            DP_MUL2: begin
                n_ma = {2'b00, r_ad};
                if (r_in.cmd == CMD_DIV) begin
                    n_mb = {r_in.b_num[31], r_in.b_num};
                end else if (r_in.cmd == CMD_NEG) begin
                    n_mb = 33'sd1;
                end else begin
                    n_mb = {2'b00, r_bd};
                end
            end
            default: begin
                n_ma = {r_in.a_num[31], r_in.a_num};
                n_mb = {2'b00, r_bd};
            end
        endcase
    end

    assign n_prod = n_ma * n_mb;

    // Combine cross products into the numerator
    always_comb begin
        if (r_in.cmd == CMD_ADD) begin
            n_num = r_p1 + r_p2;
        end else if (r_in.cmd == CMD_SUB) begin
            n_num = r_p1 - r_p2;
        end else begin
            n_num = r_p1;
        end
    end

    // Divider trial subtract
    assign n_rem_sh = {r_rem, r_q[63]};
    assign n_ge     = (n_rem_sh >= {1'b0, r_g});

    // Datapath registers
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_LOAD: begin
                r_in <= i_in_word;
                r_ad <= (i_in_word.a_den == 31'd0) ? 31'd1 : i_in_word.a_den;
                r_bd <= (i_in_word.b_den == 31'd0) ? 31'd1 : i_in_word.b_den;
            end
            DP_MUL0: r_p1  <= n_prod[63:0];
            DP_MUL1: r_p2  <= n_prod[63:0];
            DP_MUL2: r_den <= n_prod[63:0];
            DP_PREP: begin
                r_neg <= n_num[63] ^ r_den[63];
                r_n   <= n_num[63] ? 64'd0 - n_num : n_num;
                r_d   <= r_den[63] ? 64'd0 - r_den : r_den;
                r_gx  <= n_num[63] ? 64'd0 - n_num : n_num;
                r_gy  <= r_den[63] ? 64'd0 - r_den : r_den;
                r_k   <= 6'd0;
            end
            DP_GCD: begin
                if (!r_gx[0] && !r_gy[0]) begin
                    r_gx <= r_gx >> 1;
                    r_gy <= r_gy >> 1;
                    r_k  <= r_k + 6'd1;
                end else if (!r_gx[0]) begin
                    r_gx <= r_gx >> 1;
                end else if (!r_gy[0]) begin
                    r_gy <= r_gy >> 1;
                end else if (r_gx >= r_gy) begin
                    r_gx <= r_gx - r_gy;
                end else begin
                    r_gy <= r_gy - r_gx;
                end
            end
            DP_DIVN_INIT: begin
                r_g   <= (r_gx | r_gy) << r_k;
                r_q   <= r_n;
                r_rem <= 64'd0;
                r_cnt <= 6'd0;
            end
            // Take the last numerator quotient bit and start the denominator
            DP_DIVD_INIT: begin
                r_n   <= {r_q[62:0], n_ge};
                r_q   <= r_d;
                r_rem <= 64'd0;
                r_cnt <= 6'd0;
            end
            DP_DIV_STEP: begin
                r_rem <= n_ge ? 64'(n_rem_sh - {1'b0, r_g}) : n_rem_sh[63:0];
                r_q   <= {r_q[62:0], n_ge};
                r_cnt <= r_cnt + 6'd1;
            end
            DP_OUT: r_res <= n_res;
            default: begin
            end
        endcase
    end

    // Form the result word; quotient of numerator in r_n, of denominator in r_q
    always_comb begin
        n_res          = '0;
        n_res.res_den  = 31'd1;
        if (r_in.cmd > CMD_NEG) begin
            n_res.status = ST_OK;
        end else if (r_in.cmd == CMD_DIV && r_in.b_num == 32'sd0) begin
            n_res.status = ST_DIV0;
        end else if (r_in.cmd == CMD_CMP) begin
            if (r_p1 < r_p2) begin
                n_res.order = ORD_LT;
            end else if (r_p1 == r_p2) begin
                n_res.order = ORD_EQ;
            end else begin
                n_res.order = ORD_GT;
            end
        end else if (r_n == 64'd0) begin
            n_res.is_whole = 1'b1;
        end else if (r_q > LIM_POS || (r_neg ? r_n > LIM_NEG : r_n > LIM_POS)) begin
            n_res.status = ST_OVF;
        end else begin
            n_res.res_num  = r_neg ? 32'(64'd0 - r_n) : r_n[31:0];
            n_res.res_den  = r_q[30:0];
            n_res.is_whole = (r_q == 64'd1);
        end
    end

    assign o_stat.skip       = (r_in.cmd > CMD_NEG)
                            || (r_in.cmd == CMD_DIV && r_in.b_num == 32'sd0);
    assign o_stat.early_done = (r_in.cmd == CMD_CMP) || (n_num == 64'sd0);
    assign o_stat.gcd_done   = (r_gx == 64'd0) || (r_gy == 64'd0);
    assign o_stat.div_last   = (r_cnt == 6'd63);
    assign o_out_word        = r_res;

endmodule

`default_nettype wire

@@ hdl/rau_ctrl.sv @@
// Controller state machine: sequences the datapath and runs the handshakes.
// Depends on rau_pkg.
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_op        o_op
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MUL0, S_MUL1, S_MUL2, S_PREP,
        S_GCD, S_DIVN, S_DIVD, S_FIN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   n_free;

    assign n_free      = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Command for the datapath in each state
    always_comb begin
        unique case (r_state)
            S_IDLE:  o_op = (i_in_valid) ? DP_LOAD : DP_NOP;
            S_LOAD:  o_op = DP_NOP;
            S_MUL0:  o_op = DP_MUL0;
            S_MUL1:  o_op = DP_MUL1;
            S_MUL2:  o_op = DP_MUL2;
            S_PREP:  o_op = DP_PREP;
            S_GCD:   o_op = i_stat.gcd_done ? DP_DIVN_INIT : DP_GCD;
            S_DIVN:  o_op = i_stat.div_last ? DP_DIVD_INIT : DP_DIV_STEP;
            S_DIVD:  o_op = DP_DIV_STEP;
            S_FIN:   o_op = n_free ? DP_OUT : DP_NOP;
            default: o_op = DP_NOP;
        endcase
    end

    // Hold state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_LOAD;
                S_LOAD: r_state <= i_stat.skip ? S_FIN : S_MUL0;
                S_MUL0: r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_PREP;
                S_PREP: r_state <= i_stat.early_done ? S_FIN : S_GCD;
                S_GCD:  if (i_stat.gcd_done) r_state <= S_DIVN;
                S_DIVN: if (i_stat.div_last) r_state <= S_DIVD;
                S_DIVD: if (i_stat.div_last) r_state <= S_FIN;
                S_FIN: begin
                    if (n_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state == S_LOAD)
        else $error("accepted word did not start a load");

    a_divn_to_divd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVN && i_stat.div_last |=> r_state == S_DIVD)
        else $error("numerator division did not hand over");

    a_fin_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && n_free |=> r_out_valid && r_state == S_IDLE)
        else $error("finished result not presented");

endmodule

`default_nettype wire

@@ hdl/rational_arith_unit_top.sv @@
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl and rau_dpath.
//
// Usage: the input channel (i_in_valid / o_in_ready / i_in_word) takes one
// word with a command and two rationals; the output channel (o_out_valid /
// i_out_ready / o_out_word) returns one reduced result word per input word.
// One item is worked on at a time. From the accepting edge to the edge that
// raises o_out_valid, an arithmetic result passes through load, three
// multiplies, sign preparation, the binary gcd steps on the 64-bit magnitudes
// and the gcd exit step, the two divisions by the gcd and the finish step.
// Compare and zero results go from sign preparation straight to finish;
// divide by zero and unused commands go from load straight to finish.
// o_in_ready is high only while idle.
// A finished result sits in the output register; the next word is accepted
// while it waits. If the receiver stalls, the following result waits
// inside the unit until the output register frees.
// Reset (synchronous, active low) returns to idle and drops o_out_valid.
`default_nettype none

module rational_arith_unit_top
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_word     o_out_word
);

    t_dp_op   dp_op;
    t_dp_stat dp_stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_op        (dp_op)
    );

    rau_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_op       (dp_op),
        .i_in_word  (i_in_word),
        .o_stat     (dp_stat),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire

@@ tb/rational_arith_unit_top_tb.sv @@
// Testbench for rational_arith_unit_top: random and directed rational operations
// checked against an in-bench 64-bit predictor. Depends on rau_pkg and the RTL.
`default_nettype none

module rational_arith_unit_top_tb;
    import rau_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int STALL_LIMIT = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    rational_arith_unit_top #(.WORD_BITS(WORD_BITS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word)
    );

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    int        error_count;
    int        words_sent;
    int        results_seen;
    int        idle_cycles;
    bit        stim_done;
    bit        hold_off_req;
    int        hold_off_left;
    int        send_gap;
    int        recv_gap;

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint unsigned gcd_u64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic t_out_word blank_result(logic [1:0] ord, logic [1:0] st);
        t_out_word r;
        r.res_num  = '0;
        r.res_den  = 31'd1;
        r.is_whole = 1'b0;
        r.order    = ord;
        r.status   = st;
        return r;
    endfunction

    // Reduce num/den by gcd and encode, flagging overflow
    function automatic t_out_word reduce_fraction(longint num, longint den);
        t_out_word       r;
        bit              neg;
        longint unsigned n, d, g, lim_pos, lim_neg;
        neg = (num < 0) != (den < 0);
        n   = abs64(num);
        d   = abs64(den);
        if (n == 0) begin
            r = blank_result(ORD_LT, ST_OK);
            r.is_whole = 1'b1;
            return r;
        end
        g = gcd_u64(n, d);
        n = n / g;
        d = d / g;
        lim_pos = (64'd1 << (WORD_BITS - 1)) - 1;
        lim_neg = 64'd1 << (WORD_BITS - 1);
        if (d > lim_pos || (neg ? n > lim_neg : n > lim_pos))
            return blank_result(ORD_LT, ST_OVF);
        r          = blank_result(ORD_LT, ST_OK);
        r.res_num  = neg ? 32'(-n) : 32'(n);
        r.res_den  = 31'(d);
        r.is_whole = (d == 1);
        return r;
    endfunction

    function automatic t_out_word rational_result(t_in_word w);
        longint an, ad, bn, bd, l, rr;
        an = longint'(w.a_num);
        ad = (w.a_den == 0) ? 1 : longint'({1'b0, w.a_den});
        bn = longint'(w.b_num);
        bd = (w.b_den == 0) ? 1 : longint'({1'b0, w.b_den});
        case (w.cmd)
            CMD_ADD: return reduce_fraction(an * bd + bn * ad, ad * bd);
            CMD_SUB: return reduce_fraction(an * bd - bn * ad, ad * bd);
            CMD_MUL: return reduce_fraction(an * bn, ad * bd);
            CMD_DIV: begin
                if (bn == 0)
                    return blank_result(ORD_LT, ST_DIV0);
                return reduce_fraction(an * bd, ad * bn);
            end
            CMD_CMP: begin
                l  = an * bd;
                rr = bn * ad;
                return blank_result(l < rr ? ORD_LT : (l == rr ? ORD_EQ : ORD_GT), ST_OK);
            end
            CMD_NEG: return reduce_fraction(-an, ad);
            default: return blank_result(ORD_LT, ST_OK);
        endcase
    endfunction

    function automatic logic [31:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 32'(int'($urandom_range(0, 40)) - 20);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'h7fff_fffc + $urandom_range(0, 3);
            3: return 32'($urandom_range(0, 4095)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 31'd1;
            1: return 31'($urandom_range(0, 12));
            2: return 31'h7fff_fffc + 31'($urandom_range(0, 3));
            3: return 31'($urandom_range(1, 4096));
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic queue_word(logic [2:0] c, logic [31:0] an, logic [30:0] ad,
                              logic [31:0] bn, logic [30:0] bd);
        t_in_word w;
        w.cmd   = c;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        pending_words.push_back(w);
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 2) == 0)
            return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 4);
    endfunction

    // Driver: advance through pending words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold word until accepted
        end else if (send_gap > 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (pending_words.size() > 0) begin
            i_in_word  <= pending_words.pop_front();
            i_in_valid <= 1'b1;
            send_gap   <= (i_in_valid && o_in_ready) ? rand_gap() : 0;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Predict on each accepted word
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            expected_results.push_back(rational_result(i_in_word));
            words_sent <= words_sent + 1;
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready   <= 1'b0;
            recv_gap      <= 0;
            hold_off_left <= 0;
        end else if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= 3000;
            i_out_ready   <= 1'b0;
        end else if (hold_off_left > 1) begin
            hold_off_left <= hold_off_left - 1;
            i_out_ready   <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap    <= recv_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (o_out_valid && i_out_ready)
                recv_gap <= rand_gap();
        end
    end

    // Monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", o_out_word);
                error_count <= error_count + 1;
            end else begin
                e = expected_results.pop_front();
                if (o_out_word.res_num !== e.res_num) begin
                    $error("res_num exp %0d got %0d", e.res_num, o_out_word.res_num);
                    error_count <= error_count + 1;
                end
                if (o_out_word.res_den !== e.res_den) begin
                    $error("res_den exp %0d got %0d", e.res_den, o_out_word.res_den);
                    error_count <= error_count + 1;
                end
                if (o_out_word.is_whole !== e.is_whole) begin
                    $error("is_whole exp %0d got %0d", e.is_whole, o_out_word.is_whole);
                    error_count <= error_count + 1;
                end
                if (o_out_word.order !== e.order) begin
                    $error("order exp %0d got %0d", e.order, o_out_word.order);
                    error_count <= error_count + 1;
                end
                if (o_out_word.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_out_word.status);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int settle;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        i_out_ready  = 1'b0;
        error_count  = 0;
        words_sent   = 0;
        results_seen = 0;
        idle_cycles  = 0;
        stim_done    = 1'b0;
        hold_off_req = 1'b0;

        // Directed words: extremes, every command, special cases
        queue_word(CMD_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        queue_word(CMD_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
        queue_word(CMD_MUL, 32'h7fff_ffff, 31'd1, 32'h7fff_ffff, 31'd1);
        queue_word(CMD_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        queue_word(CMD_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3);
        queue_word(CMD_DIV, 32'h8000_0000, 31'h7fff_ffff, -32'sd1, 31'h7fff_ffff);
        queue_word(CMD_CMP, 32'sd1, 31'd3, 32'sd2, 31'd6);
        queue_word(CMD_CMP, -32'sd1, 31'd3, 32'sd2, 31'd6);
        queue_word(CMD_CMP, 32'sd1, 31'd2, 32'sd1, 31'd3);
        queue_word(CMD_NEG, 32'h8000_0000, 31'd1, 32'sd0, 31'd1);
        queue_word(CMD_NEG, 32'h7fff_ffff, 31'h7fff_ffff, 32'sd9, 31'd1);
        queue_word(CMD_ADD, 32'sd4, 31'd0, 32'sd6, 31'd0);
        queue_word(CMD_ADD, 32'sd6, 31'd8, 32'sd10, 31'd4);
        queue_word(CMD_ADD, 32'h7fff_ffff, 31'd1, 32'sd1, 31'd1);
        queue_word(CMD_SUB, 32'h8000_0000, 31'd1, 32'sd1, 31'd1);
        queue_word(CMD_ADD, 32'sd1, 31'h7fff_ffff, 32'sd1, 31'h7fff_fffe);
        queue_word(3'd6, 32'sd3, 31'd1, 32'sd4, 31'd1);
        queue_word(3'd7, 32'hffff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
        queue_word(CMD_MUL, 32'sd0, 31'd5, -32'sd7, 31'd3);
        queue_word(CMD_DIV, -32'sd6, 31'd4, -32'sd3, 31'd2);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random words, mostly valid commands
        for (int k = 0; k < 1000; k++) begin
            queue_word(($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                    : 3'($urandom_range(0, 5)),
                       rand_num(), rand_den(), rand_num(), rand_den());
            if (k == 300)
                hold_off_req <= 1'b1;
        end
        wait (hold_off_left > 0);
        hold_off_req <= 1'b0;

        wait (pending_words.size() == 0 && !i_in_valid);
        stim_done = 1'b1;
        wait (expected_results.size() == 0);
        settle = 0;
        while (settle < 400) begin
            @(posedge i_clk);
            settle++;
        end

        $display("Ran %0d words through all six commands plus unused codes;", words_sent);
        $display("%0d results checked, with random stalls and one long output hold-off.",
                 results_seen);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
